>>> hw/rtl/sparse_submatrix_index_remap_assert.svh
// Assertion helpers for ssir_lookup. Both sample on clk and hold off while rst_n is low.
`ifndef SPARSE_SUBMATRIX_INDEX_REMAP_ASSERT_SVH
`define SPARSE_SUBMATRIX_INDEX_REMAP_ASSERT_SVH

// Same-cycle implication.
`define SSIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ssir_pkg.sv
package ssir_pkg;

    localparam int MAX_DOF = 4096;
    localparam int ADDR_W  = $clog2(MAX_DOF);
    localparam int CNT_W   = $clog2(MAX_DOF + 1);
    localparam int IDX_W   = 16;
    localparam int LOC_W   = 12;
    localparam int VAL_W   = 64;

    typedef enum logic [1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_ENTRY = 2'd2,
        FUNC_RSVD  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_DUP   = 2'd2,
        ST_DROP  = 2'd3
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] loc_num;
    } map_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        map_entry_t        data;
    } map_wr_t;

    typedef struct packed {
        logic              busy;
        logic [ADDR_W-1:0] addr;
    } clr_status_t;

endpackage

>>> hw/rtl/ssir_map_ram.sv
module ssir_map_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 13
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> hw/rtl/ssir_clear_seq.sv
module ssir_clear_seq
    import ssir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  map_wr_t     lkp_wr,
    output clr_status_t status,
    output map_wr_t     ram_wr
);

    logic              busy_reg, busy_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            addr_next = '0;
        end
        else if (busy_reg)
        begin
            addr_next = addr_reg + ADDR_W'(1);
            if (addr_reg == ADDR_W'(MAX_DOF - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // sweep starts right out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.addr = addr_reg;

    always_comb
    begin
        if (busy_reg)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = addr_reg;
            ram_wr.data = '0;
        end
        else
        begin
            ram_wr = lkp_wr;
        end
    end

endmodule

>>> hw/rtl/ssir_lookup.sv
`include "sparse_submatrix_index_remap_assert.svh"

module ssir_lookup
    import ssir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  dof_count,
    input  clr_status_t       clr,
    // input beat
    input  logic              in_valid,
    output logic              in_ready,
    input  func_t             in_func,
    input  logic [IDX_W-1:0]  in_row,
    input  logic [IDX_W-1:0]  in_col,
    input  logic [VAL_W-1:0]  in_value,
    // map access
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_row_addr,
    output logic [ADDR_W-1:0] rd_col_addr,
    input  map_entry_t        rd_row_data,
    input  map_entry_t        rd_col_data,
    output map_wr_t           wr,
    output logic              clr_start,
    // result beat
    output logic              out_valid,
    input  logic              out_ready,
    output status_t           out_status,
    output logic [LOC_W-1:0]  out_row,
    output logic [LOC_W-1:0]  out_col,
    output logic [VAL_W-1:0]  out_value,
    output logic [CNT_W-1:0]  out_size
);

    logic              stg_valid_reg, stg_valid_next;
    func_t             stg_func_reg;
    logic [IDX_W-1:0]  stg_row_reg;
    logic [IDX_W-1:0]  stg_col_reg;
    logic [VAL_W-1:0]  stg_val_reg;

    logic              fwd_row_reg, fwd_col_reg;
    map_entry_t        fwd_data_reg;

    logic [CNT_W-1:0]  kept_count_reg, kept_count_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [LOC_W-1:0]  out_row_reg, out_col_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [CNT_W-1:0]  out_size_reg;

    logic              accept, advance;
    logic [CNT_W-1:0]  lim;
    logic              row_oor, col_oor;
    map_entry_t        row_ent, col_ent;
    status_t           res_status;
    logic [LOC_W-1:0]  res_row, res_col;
    logic [VAL_W-1:0]  res_value;
    logic [CNT_W-1:0]  res_kept;
    logic              res_wr, res_clr;

    assign advance  = stg_valid_reg && (!out_valid_reg || out_ready);
    // stall behind a begin so nothing reads the map ahead of the sweep
    assign in_ready = !clr.busy
                      && !(stg_valid_reg && (stg_func_reg == FUNC_BEGIN))
                      && (!stg_valid_reg || advance);
    assign accept   = in_valid && in_ready;

    assign rd_en       = accept;
    assign rd_row_addr = in_row[ADDR_W-1:0];
    assign rd_col_addr = in_col[ADDR_W-1:0];

    // a write landing on the edge of the read is taken from the bypass
    assign row_ent = fwd_row_reg ? fwd_data_reg : rd_row_data;
    assign col_ent = fwd_col_reg ? fwd_data_reg : rd_col_data;

    assign lim     = (dof_count > CNT_W'(MAX_DOF)) ? CNT_W'(MAX_DOF) : dof_count;
    assign row_oor = stg_row_reg >= IDX_W'(lim);
    assign col_oor = stg_col_reg >= IDX_W'(lim);

    always_comb
    begin
        res_status = ST_OK;
        res_row    = '0;
        res_col    = '0;
        res_value  = '0;
        res_kept   = kept_count_reg;
        res_wr     = 1'b0;
        res_clr    = 1'b0;
        unique case (stg_func_reg)
            FUNC_BEGIN:
            begin
                res_kept = '0;
                res_clr  = 1'b1;
            end
            FUNC_ADD:
            begin
                priority if (row_oor)
                begin
                    res_status = ST_RANGE;
                end
                else if (row_ent.valid)
                begin
                    res_status = ST_DUP;
                end
                else if (kept_count_reg >= CNT_W'(MAX_DOF))
                begin
                    res_status = ST_RANGE;
                end
                else
                begin
                    res_wr   = 1'b1;
                    res_row  = LOC_W'(kept_count_reg);
                    res_kept = kept_count_reg + CNT_W'(1);
                end
            end
            FUNC_ENTRY:
            begin
                priority if (row_oor || col_oor)
                begin
                    res_status = ST_RANGE;
                end
                else if (!row_ent.valid || !col_ent.valid
                         || (stg_val_reg[VAL_W-2:0] == '0))
                begin
                    res_status = ST_DROP;
                end
                else
                begin
                    res_row   = LOC_W'(row_ent.loc_num);
                    res_col   = LOC_W'(col_ent.loc_num);
                    res_value = stg_val_reg;
                end
            end
            FUNC_RSVD:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign wr.en           = advance && res_wr;
    assign wr.addr         = stg_row_reg[ADDR_W-1:0];
    assign wr.data.valid   = 1'b1;
    assign wr.data.loc_num = kept_count_reg[ADDR_W-1:0];
    assign clr_start       = advance && res_clr;

    assign stg_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : stg_valid_reg);
    assign kept_count_next = advance ? res_kept : kept_count_reg;
    assign out_valid_next  = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg  <= 1'b0;
            kept_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            stg_valid_reg  <= stg_valid_next;
            kept_count_reg <= kept_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_func_reg <= in_func;
            stg_row_reg  <= in_row;
            stg_col_reg  <= in_col;
            stg_val_reg  <= in_value;
            fwd_row_reg  <= wr.en && (wr.addr == rd_row_addr);
            fwd_col_reg  <= wr.en && (wr.addr == rd_col_addr);
            fwd_data_reg <= wr.data;
        end
        if (advance)
        begin
            out_status_reg <= res_status;
            out_row_reg    <= res_row;
            out_col_reg    <= res_col;
            out_value_reg  <= res_value;
            out_size_reg   <= res_kept;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_value  = out_value_reg;
    assign out_size   = out_size_reg;

    `SSIR_ASSERT_IMP(a_no_accept_in_sweep, accept, !clr.busy,
        "item accepted during map sweep")
    `SSIR_ASSERT_IMP(a_no_write_in_sweep, wr.en, !clr.busy,
        "map write collides with sweep")
    `SSIR_ASSERT_NXT(a_begin_starts_sweep, clr_start, clr.busy && (kept_count_reg == '0),
        "begin did not start sweep")
    `SSIR_ASSERT_NXT(a_add_counts_one, wr.en,
        kept_count_reg == ($past(kept_count_reg) + CNT_W'(1)),
        "kept count not advanced by one")

endmodule

>>> hw/rtl/sparse_submatrix_index_remap.sv
// Sparse submatrix index remap. Each input beat carries a func in s_tuser: begin clears
// the global-to-local map, add assigns the next local number to a kept global index
// (checked against min(dof_count, 4096) and against earlier adds), and entry looks up
// both ends of a matrix nonzero and emits it in local coordinates when both are mapped
// and the value is not +/-0.0. Every input beat yields exactly one result beat, with the
// status in m_tuser. Without a sweep or a stall on m_tready the block sustains one item
// per clock through a two-read, one-write map RAM, with a bypass for an add followed at
// once by a read of the same index; an item passes a stage register, with the map read,
// then the result register. After reset, and after every begin item, the map is swept
// one entry per cycle over all 4096 entries with s_tready low. Write configuration only
// while no item is in flight; the new size applies to every item checked after the write.
module sparse_submatrix_index_remap
    import ssir_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // dof_count register
    input  logic         cfg_we,
    input  logic [12:0]  cfg_wdata,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // row_index[15:0], col_index[31:16], value_bits[95:32]
    input  logic [1:0]   s_tuser,   // func[1:0]
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // sub_row[11:0], sub_col[23:12],
                                    // out_value_bits[87:24], sub_size[100:88], zero pad
    output logic [1:0]   m_tuser    // status[1:0]
);

    logic [CNT_W-1:0]  dof_count_reg, dof_count_next;

    clr_status_t       clr;
    map_wr_t           lkp_wr, ram_wr;
    logic              clr_start;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_row_addr, rd_col_addr;
    map_entry_t        rd_row_data, rd_col_data;

    status_t           out_status;
    logic [LOC_W-1:0]  out_row, out_col;
    logic [VAL_W-1:0]  out_value;
    logic [CNT_W-1:0]  out_size;

    // size register: reset to the full map depth
    assign dof_count_next = cfg_we ? CNT_W'(cfg_wdata) : dof_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dof_count_reg <= CNT_W'(MAX_DOF);
        end
        else
        begin
            dof_count_reg <= dof_count_next;
        end
    end

    ssir_lookup u_lookup (
        .clk         (clk),
        .rst_n       (rst_n),
        .dof_count   (dof_count_reg),
        .clr         (clr),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (func_t'(s_tuser)),
        .in_row      (s_tdata[15:0]),
        .in_col      (s_tdata[31:16]),
        .in_value    (s_tdata[95:32]),
        .rd_en       (rd_en),
        .rd_row_addr (rd_row_addr),
        .rd_col_addr (rd_col_addr),
        .rd_row_data (rd_row_data),
        .rd_col_data (rd_col_data),
        .wr          (lkp_wr),
        .clr_start   (clr_start),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .out_size    (out_size)
    );

    // sweep owns the RAM write port while busy
    ssir_clear_seq u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (clr_start),
        .lkp_wr (lkp_wr),
        .status (clr),
        .ram_wr (ram_wr)
    );

    ssir_map_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W ($bits(map_entry_t))
    ) u_map (
        .clk     (clk),
        .we      (ram_wr.en),
        .waddr   (ram_wr.addr),
        .wdata   (ram_wr.data),
        .re      (rd_en),
        .raddr_a (rd_row_addr),
        .raddr_b (rd_col_addr),
        .rdata_a (rd_row_data),
        .rdata_b (rd_col_data)
    );

    // pack the result beat, lowest field first
    assign m_tdata = {3'b000, out_size, out_value, out_col, out_row};
    assign m_tuser = out_status;

endmodule

>>> test/sparse_submatrix_index_remap_tb.sv
module sparse_submatrix_index_remap_tb;
    import ssir_pkg::*;

    localparam int LONG_HOLD   = 150;     // receiver hold-off that backs the block up
    localparam int CYCLE_LIMIT = 300000;  // seven map sweeps plus worst-case idling, several times
    localparam int REPORT_MAX  = 10;

    // One input beat as the sender sees it.
    typedef struct packed {
        func_t       func;
        logic [15:0] row;
        logic [15:0] col;
        logic [63:0] val;
    } remap_req_t;

    // One result beat, unpacked.
    typedef struct packed {
        status_t           status;
        logic [LOC_W-1:0]  lrow;
        logic [LOC_W-1:0]  lcol;
        logic [VAL_W-1:0]  val;
        logic [CNT_W-1:0]  size;
    } remap_rsp_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [12:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata   = '0;   // row_index[15:0], col_index[31:16], value_bits[95:32]
    logic [1:0]   s_tuser   = '0;   // func[1:0]
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [103:0] m_tdata;          // sub_row[11:0], sub_col[23:12],
                                    // out_value_bits[87:24], sub_size[100:88]
    logic [1:0]   m_tuser;          // status[1:0]

    sparse_submatrix_index_remap u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: a private copy of the map, the kept count and dof_count.
    // ------------------------------------------------------------------
    logic [12:0]      dof_setting = 13'd4096;
    bit               kept_valid [MAX_DOF];
    logic [LOC_W-1:0] kept_local [MAX_DOF];
    logic [CNT_W-1:0] kept_total = '0;

    // Advance the private state by one input beat and return its result beat.
    function automatic remap_rsp_t predict_remap(remap_req_t req);
        remap_rsp_t  rsp;
        int unsigned lim;
        rsp = '0;
        // dof_count above the map depth saturates at the map depth
        lim = (dof_setting > MAX_DOF) ? MAX_DOF : dof_setting;
        case (req.func)
            FUNC_BEGIN:
            begin
                foreach (kept_valid[i])
                    kept_valid[i] = 1'b0;
                kept_total = '0;
            end
            FUNC_ADD:
            begin
                if (req.row >= lim)
                    rsp.status = ST_RANGE;
                else if (kept_valid[req.row])
                    rsp.status = ST_DUP;
                else if (kept_total >= MAX_DOF)
                    rsp.status = ST_RANGE;
                else
                begin
                    kept_valid[req.row] = 1'b1;
                    kept_local[req.row] = kept_total[LOC_W-1:0];
                    rsp.lrow = kept_total[LOC_W-1:0];
                    kept_total++;
                end
            end
            FUNC_ENTRY:
            begin
                // range check first: the map is not consulted for a bad end
                if (req.row >= lim || req.col >= lim)
                    rsp.status = ST_RANGE;
                else if (!kept_valid[req.row] || !kept_valid[req.col] || req.val[62:0] == '0)
                    rsp.status = ST_DROP;   // unmapped end, or +0.0 / -0.0
                else
                begin
                    rsp.lrow = kept_local[req.row];
                    rsp.lcol = kept_local[req.col];
                    rsp.val  = req.val;
                end
            end
            default: ;   // reserved func: status ok, state untouched
        endcase
        rsp.size = kept_total;
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Failure bookkeeping
    // ------------------------------------------------------------------
    int fail_count = 0;

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s", what);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
            note_failure($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
    endfunction

    // ------------------------------------------------------------------
    // Sender: drain pending_requests onto the slave side, one beat at a time.
    // ------------------------------------------------------------------
    remap_req_t pending_requests [$];
    remap_rsp_t predicted_results [$];
    remap_req_t bus_req;
    int         send_wait     = 0;
    int         send_idle_pct = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            // predict at the accepting edge so config and map stay in step
            if (s_tvalid && s_tready)
                predicted_results.push_back(predict_remap(bus_req));
            // hold the beat until it is taken; otherwise idle or load the next one
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    bus_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {bus_req.val, bus_req.col, bus_req.row};
                    s_tuser  <= bus_req.func;
                    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
                        send_wait = $urandom_range(19, 1);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each result beat against the oldest prediction and
    // drive m_tready with random stalls and on request one long hold-off.
    // ------------------------------------------------------------------
    int recv_wait     = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;

    always @(posedge clk)
    begin : result_check
        remap_rsp_t got;
        remap_rsp_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tuser);
                got.lrow   = m_tdata[11:0];
                got.lcol   = m_tdata[23:12];
                got.val    = m_tdata[87:24];
                got.size   = m_tdata[100:88];
                if (predicted_results.size() == 0)
                    note_failure($sformatf("result beat with nothing pending: %p", got));
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("sub_row", want.lrow, got.lrow);
                    check_field("sub_col", want.lcol, got.lcol);
                    check_field("out_value_bits", want.val, got.val);
                    check_field("sub_size", want.size, got.size);
                end
            end
            // a new request starts the long hold-off, counted here
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                recv_wait   = LONG_HOLD;
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
                    recv_wait = $urandom_range(19, 1);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sparse_submatrix_index_remap_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation. gen_pool tracks the indices the stream has kept,
    // so entries can be aimed at mapped coordinates.
    // ------------------------------------------------------------------
    int unsigned gen_lim = MAX_DOF;
    int unsigned gen_pool [$];
    bit          gen_seen [MAX_DOF];

    function automatic void push_item(func_t f, int unsigned row, int unsigned col,
                                      logic [63:0] v);
        remap_req_t req;
        req.func = f;
        req.row  = 16'(row);
        req.col  = 16'(col);
        req.val  = v;
        pending_requests.push_back(req);
        if (f == FUNC_BEGIN)
        begin
            gen_pool.delete();
            foreach (gen_seen[i])
                gen_seen[i] = 1'b0;
        end
        else if (f == FUNC_ADD && req.row < gen_lim && !gen_seen[req.row])
        begin
            gen_seen[req.row] = 1'b1;
            gen_pool.push_back(req.row);
        end
    endfunction

    function automatic logic [63:0] random_bits();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned index_below_limit();
        return (gen_lim > 0) ? $urandom_range(gen_lim - 1, 0) : $urandom_range(65535, 0);
    endfunction

    function automatic int unsigned kept_index();
        return (gen_pool.size() > 0) ? gen_pool[$urandom_range(gen_pool.size() - 1, 0)]
                                     : index_below_limit();
    endfunction

    // Well-formed run: optional begin, a burst of adds, then mostly entries
    // between kept indices, salted with duplicates, bad indices and noise.
    task automatic random_phase(input int n_items, input bit with_begin);
        int          n_add;
        int          pick;
        int unsigned row;
        int unsigned col;
        logic [63:0] v;
        if (with_begin)
            push_item(FUNC_BEGIN, $urandom, $urandom, random_bits());
        n_add = (gen_lim < 2) ? 2 : $urandom_range((gen_lim < 24) ? gen_lim + 1 : 24, 2);
        for (int i = 0; i < n_items; i++)
        begin
            pick = (i < n_add) ? 0 : $urandom_range(99);
            v = random_bits();
            if (pick < 10)
                push_item(FUNC_ADD, index_below_limit(), $urandom, v);
            else if (pick < 13)
                push_item(FUNC_ADD, kept_index(), $urandom, v);
            else if (pick < 16)
                push_item(FUNC_ADD, $urandom_range(65535, gen_lim), $urandom, v);
            else if (pick < 80)
            begin
                // zero values of either sign get dropped
                if ($urandom_range(19) == 0)
                    v = $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h0;
                push_item(FUNC_ENTRY, kept_index(), kept_index(), v);
            end
            else if (pick < 88)
            begin
                row = kept_index();
                col = index_below_limit();
                if ($urandom_range(1))
                    push_item(FUNC_ENTRY, row, col, v);
                else
                    push_item(FUNC_ENTRY, col, row, v);
            end
            else if (pick < 94)
            begin
                row = kept_index();
                col = $urandom_range(65535, gen_lim);
                if ($urandom_range(1))
                    push_item(FUNC_ENTRY, row, col, v);
                else
                    push_item(FUNC_ENTRY, col, row, v);
            end
            else if (pick < 97)
                push_item(FUNC_RSVD, $urandom, $urandom, v);
            else
                push_item(FUNC_ENTRY, $urandom, $urandom, v);
        end
    endtask

    // Wait until every beat is sent and every result is back, plus slack.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || predicted_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write dof_count; only called with the block drained.
    task automatic write_dof(input logic [12:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        dof_setting = v;
        gen_lim     = (v > MAX_DOF) ? MAX_DOF : v;
        @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset size (4096), edges of the index range, duplicates,
        // NaN passthrough, both signed zeros, unmapped ends, reserved func.
        set_idling(0, 0);
        push_item(FUNC_ADD, 0, 0, '0);
        push_item(FUNC_ADD, 4095, 65535, '1);
        push_item(FUNC_ADD, 4096, 0, '0);
        push_item(FUNC_ADD, 65535, 0, '0);
        push_item(FUNC_ADD, 0, 0, '0);
        push_item(FUNC_ADD, 7, 0, '0);
        push_item(FUNC_ENTRY, 0, 4095, 64'h3FF0_0000_0000_0000);
        push_item(FUNC_ENTRY, 4095, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(FUNC_ENTRY, 0, 0, 64'h0);
        push_item(FUNC_ENTRY, 0, 7, 64'h8000_0000_0000_0000);
        push_item(FUNC_ENTRY, 0, 5, 64'h0000_0000_0000_0001);
        push_item(FUNC_ENTRY, 5, 0, 64'hC000_0000_0000_0000);
        push_item(FUNC_ENTRY, 65535, 0, 64'h7FF8_0000_0000_0000);
        push_item(FUNC_ENTRY, 0, 65535, 64'h4000_0000_0000_0000);
        push_item(FUNC_RSVD, 65535, 65535, '1);
        push_item(FUNC_BEGIN, 65535, 65535, '1);
        push_item(FUNC_ADD, 4095, 0, '0);
        push_item(FUNC_ENTRY, 0, 4095, 64'h3FF0_0000_0000_0000);
        wait_drained();

        // size zero: every index is out of range
        write_dof(13'd0);
        push_item(FUNC_ADD, 0, 0, '0);
        push_item(FUNC_ENTRY, 0, 0, 64'h1);
        wait_drained();

        // size above the map depth saturates; the earlier map entries stay
        write_dof(13'd8191);
        push_item(FUNC_ADD, 4095, 0, '0);
        push_item(FUNC_ADD, 4096, 0, '0);
        push_item(FUNC_ADD, 100, 0, '0);
        push_item(FUNC_ENTRY, 4095, 100, 64'hDEAD_BEEF_0123_4567);
        wait_drained();

        // smallest nonzero size
        write_dof(13'd1);
        push_item(FUNC_ADD, 0, 0, '0);
        push_item(FUNC_ADD, 1, 0, '0);
        push_item(FUNC_ENTRY, 0, 0, 64'h0000_0000_0000_0002);
        push_item(FUNC_ENTRY, 0, 4095, 64'h0000_0000_0000_0002);
        wait_drained();

        // Random runs over several sizes and idling mixes.
        write_dof(13'd4096);
        set_idling(10, 10);
        random_phase(90, 1'b1);
        wait_drained();

        // hold the result side off while the sender keeps offering
        write_dof(13'd200);
        set_idling(5, 0);
        hold_requests++;
        random_phase(90, 1'b0);
        wait_drained();

        write_dof(13'd8191);
        set_idling(30, 5);
        random_phase(90, 1'b1);
        wait_drained();

        // same size, no begin, with heavier stalls on the receiver side
        set_idling(5, 30);
        random_phase(80, 1'b0);
        wait_drained();

        write_dof(13'($urandom_range(4096, 1)));
        set_idling(15, 15);
        random_phase(90, 1'b1);
        wait_drained();

        write_dof(13'd3);
        set_idling(10, 10);
        random_phase(60, 1'b1);
        wait_drained();

        write_dof(13'd0);
        random_phase(20, 1'b0);
        wait_drained();

        // closing run at full rate, no idling on either side
        write_dof(13'd4096);
        set_idling(0, 0);
        random_phase(100, 1'b1);
        wait_drained();

        repeat (8) @(posedge clk);
        if (fail_count == 0 && predicted_results.size() == 0)
            $display("sparse_submatrix_index_remap_tb OK");
        else
            $display("sparse_submatrix_index_remap_tb NOT OK");
        $finish;
    end

endmodule

>>> sparse_submatrix_index_remap.f
+incdir+hw/rtl
hw/rtl/ssir_pkg.sv
hw/rtl/ssir_map_ram.sv
hw/rtl/ssir_clear_seq.sv
hw/rtl/ssir_lookup.sv
hw/rtl/sparse_submatrix_index_remap.sv
test/sparse_submatrix_index_remap_tb.sv
